// ===== sv/min_heap_key_update_defines.svh =====
// Assertion macros for the min-heap key update block.
`ifndef MIN_HEAP_KEY_UPDATE_DEFINES_SVH
`define MIN_HEAP_KEY_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, held off during reset
`define MHKU_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mhku: implication failed");
// next-cycle implication, held off during reset
`define MHKU_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mhku: next-cycle implication failed");
`else
`define MHKU_ASSERT_IMP(label, clk, rst_n, a, b)
`define MHKU_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== sv/mhku_pkg.sv =====
// Shared types and constants for the min-heap key update block.
`default_nettype none
package mhku_pkg;

  localparam int IDX_W          = 5;
  localparam int KEY_W          = 32;
  localparam int CNT_W          = 5;
  localparam int HEAP_DEPTH_DEF = 16;
  localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_DEC  = 2'd1,
    REQ_INC  = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_PICK,
    S_DN_CMP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_IN,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WS_KEY,
    WS_RDATA,
    WS_CHILD
  } wr_src_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_PARENT,
    POS_CHILD
  } pos_op_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_src_t wr_src;
    logic    ld_old;
    pos_op_t pos_op;
    logic    child_left;
    logic    child_right;
    logic    res_ld;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic bad;
    logic at_root;
    logic key_lt_rd;
    logic left_in;
    logic right_in;
    logic rd_lt_child;
    logic child_lt_key;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/min_heap_key_update.sv =====
// Top level of the min-heap key update block.
// Keeps a 1-based binary min-heap of signed 32-bit keys in a small RAM.
// Input channel (in_valid/in_stall) takes one request item: load, decrease
// key (sift up), increase key (sift down) or read. The result channel
// (out_valid/out_stall) returns one item per request: value, final_index,
// warn and bad_index. cfg_valid/cfg_ready writes active_count; cfg_ready is
// always high. Writes are to be made only while the block is idle; the
// block itself does not enforce this. From acceptance to out_valid: load,
// read and bad index pass the old-value step; decrease reads the parent and
// compares per level moved, up to the root; increase reads the left child,
// reads the right one, picks when both exist and compares, per level moved.
// The single RAM read port, with its registered read, sets the steps per
// level. One item is in work at a time; the next is accepted the cycle
// after its result enters the output register, even while that result is
// still stalled.
// Reset (rst_n low, synchronous) sets active_count to 16 and empties the
// pipeline; heap entries are undefined until loaded. While out_stall is
// high the result holds and a finished item waits in the sequencer.
`default_nettype none
`include "min_heap_key_update_defines.svh"
module min_heap_key_update
  import mhku_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_req_type,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [KEY_W-1:0] in_key,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [KEY_W-1:0]      out_value,
  output logic [IDX_W-1:0]             out_final_index,
  output logic                         out_warn,
  output logic                         out_bad_index,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CNT_W-1:0]        cfg_active_count
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mhku_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhku_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_index         (in_index),
    .in_key           (in_key),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_active_count (cfg_active_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_final_index  (out_final_index),
    .out_warn         (out_warn),
    .out_bad_index    (out_bad_index),
    .cmd              (cmd),
    .sts              (sts)
  );

  // an accepted item keeps the sequencer busy in the cycle after acceptance
  `MHKU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // an ignored request reports position 0 and no warning
  `MHKU_ASSERT_IMP(a_bad_fields, clk, rst_n, out_valid && out_bad_index,
                   (out_final_index == '0) && !out_warn && (out_value == '0))
  // a served request always lands on a real heap position
  `MHKU_ASSERT_IMP(a_good_pos, clk, rst_n, out_valid && !out_bad_index,
                   out_final_index != '0)
  // a result is never produced in the cycle right after acceptance
  `MHKU_ASSERT_NXT(a_no_early_result, clk, rst_n, in_valid && !in_stall && !out_valid,
                   !out_valid)

endmodule
`default_nettype wire

// ===== sv/mhku_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mhku_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mhku_ctrl.sv =====
// Sequencer for load, read and sift-up / sift-down requests.
`default_nettype none
module mhku_ctrl
  import mhku_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_OLD;
      end
      S_OLD: begin
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else begin
          unique case (sts.req)
            REQ_DEC: state_nxt = S_UP_RD;
            REQ_INC: state_nxt = S_DN_RDL;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_UP_RD:   state_nxt = sts.at_root ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_nxt = sts.key_lt_rd ? S_UP_RD : S_DONE;
      S_DN_RDL:  state_nxt = sts.left_in ? S_DN_RDR : S_DONE;
      S_DN_RDR:  state_nxt = sts.right_in ? S_DN_PICK : S_DN_CMP;
      S_DN_PICK: state_nxt = S_DN_CMP;
      S_DN_CMP:  state_nxt = sts.child_lt_key ? S_DN_RDL : S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch  = accept;
        cmd.rd_en  = accept;
        cmd.rd_sel = RD_IN;
      end
      S_OLD: begin
        cmd.ld_old = 1'b1;
        cmd.wr_en  = !sts.bad && (sts.req == REQ_LOAD);
        cmd.wr_src = WS_KEY;
      end
      S_UP_RD: begin
        // at the root the moving key lands where it is
        cmd.wr_en  = sts.at_root;
        cmd.wr_src = WS_KEY;
        cmd.rd_en  = !sts.at_root;
        cmd.rd_sel = RD_PARENT;
      end
      S_UP_CMP: begin
        cmd.wr_en  = 1'b1;
        if (sts.key_lt_rd) begin
          cmd.wr_src = WS_RDATA;
          cmd.pos_op = POS_PARENT;
        end else begin
          cmd.wr_src = WS_KEY;
        end
      end
      S_DN_RDL: begin
        cmd.wr_en  = !sts.left_in;
        cmd.wr_src = WS_KEY;
        cmd.rd_en  = sts.left_in;
        cmd.rd_sel = RD_LEFT;
      end
      S_DN_RDR: begin
        cmd.child_left = 1'b1;
        cmd.rd_en      = sts.right_in;
        cmd.rd_sel     = RD_RIGHT;
      end
      S_DN_PICK: begin
        cmd.child_right = sts.rd_lt_child;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.child_lt_key) begin
          cmd.wr_src = WS_CHILD;
          cmd.pos_op = POS_CHILD;
        end else begin
          cmd.wr_src = WS_KEY;
        end
      end
      S_DONE: begin
        cmd.res_ld = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mhku_dp.sv =====
// Datapath: heap store, position and key registers, result register.
`default_nettype none
module mhku_dp
  import mhku_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [1:0]              in_req_type,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic                    cfg_valid,
  input  wire logic [CNT_W-1:0]        cfg_active_count,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [KEY_W-1:0]      out_value,
  output logic [IDX_W-1:0]             out_final_index,
  output logic                         out_warn,
  output logic                         out_bad_index,
  input  wire cmd_t                    cmd,
  output sts_t                         sts
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int PW = $clog2(HEAP_DEPTH + 1);
  localparam int CW = ((PW > CNT_W) ? PW : CNT_W) + 1;

  logic [CNT_W-1:0]        act_r;
  logic                    out_valid_r;
  req_t                    req_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [KEY_W-1:0] key_r;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic signed [KEY_W-1:0] child_r;
  logic [PW-1:0]           cpos_r;
  logic                    warn_r;
  logic signed [KEY_W-1:0] val_r;
  logic signed [KEY_W-1:0] out_value_r;
  logic [IDX_W-1:0]        out_fin_r;
  logic                    out_warn_r;
  logic                    out_bad_r;

  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] rd_s;
  logic [CW-1:0]           n_c, left_c, right_c, rd_pos;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [KEY_W-1:0]        wr_data;
  logic                    bad;
  logic                    out_free;

  assign rd_s    = $signed(rdata);
  // bound in force is min(active_count, depth)
  assign n_c     = (CW'(act_r) > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : CW'(act_r);
  assign left_c  = CW'({pos_r, 1'b0});
  assign right_c = left_c + CW'(1);
  assign bad     = (idx_r == '0) || (CW'(idx_r) > n_c);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IN:     rd_pos = CW'(in_index);
      RD_PARENT: rd_pos = CW'(pos_r >> 1);
      RD_LEFT:   rd_pos = left_c;
      RD_RIGHT:  rd_pos = right_c;
      default:   rd_pos = left_c;
    endcase
  end

  // positions are 1-based, store addresses 0-based
  assign rd_addr = AW'(rd_pos - CW'(1));
  assign wr_addr = AW'(CW'(pos_r) - CW'(1));

  always_comb begin
    unique case (cmd.wr_src)
      WS_KEY:   wr_data = key_r;
      WS_RDATA: wr_data = rdata;
      WS_CHILD: wr_data = child_r;
      default:  wr_data = key_r;
    endcase
  end

  mhku_ram #(
    .WIDTH (KEY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  always_comb begin
    unique case (cmd.pos_op)
      POS_PARENT: pos_nxt = pos_r >> 1;
      POS_CHILD:  pos_nxt = cpos_r;
      default:    pos_nxt = pos_r;
    endcase
  end

  always_comb begin
    sts.req          = req_r;
    sts.bad          = bad;
    sts.at_root      = (pos_r == PW'(1));
    sts.key_lt_rd    = key_r < rd_s;
    sts.left_in      = left_c <= n_c;
    sts.right_in     = right_c <= n_c;
    sts.rd_lt_child  = rd_s < child_r;
    sts.child_lt_key = child_r < key_r;
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) act_r <= cfg_active_count;
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= req_t'(in_req_type);
      idx_r <= in_index;
      key_r <= in_key;
      pos_r <= PW'(in_index);
    end else begin
      pos_r <= pos_nxt;
    end
    if (cmd.ld_old) begin
      warn_r <= ((req_r == REQ_DEC) && (key_r >= rd_s)) ||
                ((req_r == REQ_INC) && (key_r <= rd_s));
      val_r  <= (req_r == REQ_READ) ? rd_s : key_r;
    end
    if (cmd.child_left) begin
      child_r <= rd_s;
      cpos_r  <= PW'(left_c);
    end else if (cmd.child_right) begin
      child_r <= rd_s;
      cpos_r  <= PW'(right_c);
    end
    if (cmd.res_ld) begin
      out_value_r <= bad ? '0 : val_r;
      out_fin_r   <= bad ? '0 : IDX_W'(pos_r);
      out_warn_r  <= !bad && warn_r;
      out_bad_r   <= bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_final_index = out_fin_r;
  assign out_warn        = out_warn_r;
  assign out_bad_index   = out_bad_r;

endmodule
`default_nettype wire
